### rtl/uniform_bin_histogram_assert.svh
// ----------------------------------------------------------------------------
// Uniform bin histogram assertion macros
// Concurrent assertion wrappers. They expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_BIN_HISTOGRAM_ASSERT_SVH
`define UNIFORM_BIN_HISTOGRAM_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define UHIST_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uhist assertion failed");
// Next-cycle implication.
`define UHIST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uhist assertion failed");
`else
`define UHIST_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UHIST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/uhist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Uniform bin histogram package
// Widths, command and register codes, and the types shared between modules.
// ----------------------------------------------------------------------------
package uhist_pkg;

  localparam int BINS_MAX_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CMD_W       = 2;
  localparam int SAMPLE_W    = 32;
  localparam int IDX_W       = 8;
  localparam int SCALE_W     = 32;
  localparam int BIN_COUNT_W = 9;
  localparam int OUT_COUNT_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Depth of the result queue; it also bounds the items in flight.
  localparam int FIFO_DEPTH = 8;

  localparam logic [CMD_W-1:0] CMD_ADD        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd2;

  localparam logic [SAMPLE_W-1:0]    MIN_VALUE_RST = 32'd0;
  localparam logic [SCALE_W-1:0]     BIN_SCALE_RST = 32'h0001_0000;
  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 9'd256;

  // One operation heading for the bin memory.
  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
    logic             touch;   // the memory entry is read (and maybe written)
    logic [IDX_W-1:0] sel;     // bin reported with the result
  } uhist_op_t;

  // One finished result.
  typedef struct packed {
    logic                   valid;
    logic [IDX_W-1:0]       sel;
    logic [OUT_COUNT_W-1:0] count;
  } uhist_res_t;

endpackage
`default_nettype wire

### rtl/uhist_bin_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bin address calculation
// Subtracts the lower edge, scales by a 32x32 multiply and clamps the bin.
// ----------------------------------------------------------------------------
module uhist_bin_calc #(
  parameter int BINS_MAX = uhist_pkg::BINS_MAX_DEF,
  localparam int BIN_W = $clog2(BINS_MAX)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic [uhist_pkg::CMD_W-1:0]       command,
  input  logic [uhist_pkg::SAMPLE_W-1:0]    sample,
  input  logic [uhist_pkg::IDX_W-1:0]       bin_index,
  input  logic [uhist_pkg::SAMPLE_W-1:0]    min_value,
  input  logic [uhist_pkg::SCALE_W-1:0]     bin_scale,
  input  logic [uhist_pkg::BIN_COUNT_W-1:0] bin_count,
  output uhist_pkg::uhist_op_t              op,
  output logic [BIN_W-1:0]                  addr
);
  import uhist_pkg::*;

  localparam int BCW = (BIN_W + 1 > BIN_COUNT_W) ? BIN_W + 1 : BIN_COUNT_W;
  localparam int IXW = (BIN_W > IDX_W) ? BIN_W : IDX_W;

  logic [SAMPLE_W:0]      diff;
  logic                   s1_valid;
  logic [CMD_W-1:0]       s1_cmd;
  logic [IDX_W-1:0]       s1_idx;
  logic                   s1_pos;
  logic [SAMPLE_W-1:0]    s1_diff;
  logic [2*SCALE_W-1:0]   prod;
  logic                   s2_valid;
  logic [CMD_W-1:0]       s2_cmd;
  logic [IDX_W-1:0]       s2_idx;
  logic [SCALE_W-1:0]     s2_bin;
  logic [BCW-1:0]         bc_ext;
  logic [BIN_W-1:0]       last;
  logic [BIN_W-1:0]       bin_clamped;
  logic [IXW-1:0]         idx_ext;
  logic [IXW-1:0]         bin_ext;
  logic                   in_range;

  // Sign-extended difference; positive values fit in 32 unsigned bits.
  assign diff = {sample[SAMPLE_W-1], sample} - {min_value[SAMPLE_W-1], min_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= take;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd  <= command;
      s1_idx  <= bin_index;
      s1_pos  <= !diff[SAMPLE_W] && (diff != '0);
      s1_diff <= diff[SAMPLE_W-1:0];
    end
  end

  assign prod = (2*SCALE_W)'(s1_diff) * (2*SCALE_W)'(bin_scale);

  always_ff @(posedge clk) begin
    s2_cmd <= s1_cmd;
    s2_idx <= s1_idx;
    s2_bin <= s1_pos ? prod[2*SCALE_W-1:SCALE_W] : '0;
  end

  // Last bin in use: a count of zero acts as one, a count past the store as
  // the whole store.
  always_comb begin
    bc_ext = BCW'(bin_count);
    if (bc_ext == '0) begin
      last = '0;
    end else if (bc_ext > BCW'(BINS_MAX)) begin
      last = BIN_W'(BINS_MAX - 1);
    end else begin
      last = BIN_W'(bc_ext - 1'b1);
    end
  end

  assign bin_clamped = (s2_bin > 32'(last)) ? last : s2_bin[BIN_W-1:0];
  assign idx_ext     = IXW'(s2_idx);
  assign bin_ext     = IXW'(bin_clamped);
  assign in_range    = 32'(s2_idx) < 32'(BINS_MAX);

  always_comb begin
    op.valid = s2_valid;
    op.cmd   = s2_cmd;
    unique case (s2_cmd)
      CMD_ADD: begin
        op.touch = 1'b1;
        op.sel   = bin_ext[IDX_W-1:0];
        addr     = bin_clamped;
      end
      CMD_READ, CMD_READ_CLEAR: begin
        op.touch = in_range;
        op.sel   = s2_idx;
        addr     = idx_ext[BIN_W-1:0];
      end
      default: begin
        op.touch = 1'b0;
        op.sel   = s2_idx;
        addr     = idx_ext[BIN_W-1:0];
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/uhist_bin_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bin counter memory
// Read-modify-write of the counters with write forwarding and a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
module uhist_bin_mem #(
  parameter int BINS_MAX    = uhist_pkg::BINS_MAX_DEF,
  parameter int COUNT_WIDTH = uhist_pkg::COUNT_WIDTH_DEF,
  localparam int BIN_W = $clog2(BINS_MAX)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  uhist_pkg::uhist_op_t  op,
  input  logic [BIN_W-1:0]      addr,
  output logic                  clearing,
  output uhist_pkg::uhist_res_t res
);
  import uhist_pkg::*;

  localparam int CXW = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

  logic [COUNT_WIDTH-1:0] mem [BINS_MAX];
  logic [COUNT_WIDTH-1:0] rdata;
  uhist_op_t              s4_op;
  logic [BIN_W-1:0]       s4_addr;
  logic                   clr_active;
  logic [BIN_W-1:0]       clr_addr;
  logic                   wr_en;
  logic [BIN_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   fwd_valid;
  logic [BIN_W-1:0]       fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] new_val;
  logic [COUNT_WIDTH-1:0] res_full;
  logic [CXW-1:0]         res_ext;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (op.valid && op.touch) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_op      <= '0;
      fwd_valid  <= 1'b0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      s4_op     <= op;
      fwd_valid <= wr_en;
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == BIN_W'(BINS_MAX - 1)) begin
          clr_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_addr  <= addr;
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  // The write of the previous operation lands in the same edge as this
  // operation's read, so the memory returns the old value; take it from the
  // forwarding register instead.
  assign cur = (fwd_valid && fwd_addr == s4_addr) ? fwd_data : rdata;

  always_comb begin
    unique case (s4_op.cmd)
      CMD_ADD:        new_val = (&cur) ? cur : cur + 1'b1;
      CMD_READ_CLEAR: new_val = '0;
      default:        new_val = cur;
    endcase
  end

  assign wr_en   = clr_active
                   || (s4_op.valid && s4_op.touch && (s4_op.cmd != CMD_READ));
  assign wr_addr = clr_active ? clr_addr : s4_addr;
  assign wr_data = clr_active ? '0 : new_val;

  always_comb begin
    if (!s4_op.touch) begin
      res_full = '0;
    end else if (s4_op.cmd == CMD_ADD) begin
      res_full = new_val;
    end else begin
      res_full = cur;
    end
  end

  assign res_ext   = CXW'(res_full);
  assign res.valid = s4_op.valid;
  assign res.sel   = s4_op.sel;
  assign res.count = res_ext[OUT_COUNT_W-1:0];
  assign clearing  = clr_active;

endmodule
`default_nettype wire

### rtl/uhist_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that holds results until the output side takes them.
// ----------------------------------------------------------------------------
module uhist_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  uhist_pkg::uhist_res_t             res,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [uhist_pkg::IDX_W-1:0]       bin_selected,
  output logic [uhist_pkg::OUT_COUNT_W-1:0] count
);
  import uhist_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [IDX_W-1:0]       sel_q [FIFO_DEPTH];
  logic [OUT_COUNT_W-1:0] cnt_q [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       fill;
  logic                   pop;

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (res.valid) begin
      sel_q[wr_ptr] <= res.sel;
      cnt_q[wr_ptr] <= res.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (res.valid && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !res.valid) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign out_valid    = (fill != '0);
  assign bin_selected = sel_q[rd_ptr];
  assign count        = cnt_q[rd_ptr];

endmodule
`default_nettype wire

### rtl/uniform_bin_histogram.sv
// A result passes the difference, product and memory stages and the result
// queue before it is offered. Throughput: one item per cycle unless the input
// is stalled; the bin memory is read, updated and written back every cycle,
// with forwarding between neighbouring items. Reset: synchronous; a clearing
// pass then zeroes the memory one entry per cycle, while no item is taken.
`default_nettype none
// ----------------------------------------------------------------------------
// Uniform bin histogram
// Bins signed Q16.16 samples into uniform bins with saturating counters, and
// serves read and read-and-clear commands on single bins.
// ----------------------------------------------------------------------------
`include "uniform_bin_histogram_assert.svh"

module uniform_bin_histogram #(
  parameter int BINS_MAX    = uhist_pkg::BINS_MAX_DEF,
  parameter int COUNT_WIDTH = uhist_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [uhist_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uhist_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [uhist_pkg::CMD_W-1:0]       command,
  input  logic [uhist_pkg::SAMPLE_W-1:0]    sample,
  input  logic [uhist_pkg::IDX_W-1:0]       bin_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [uhist_pkg::IDX_W-1:0]       bin_selected,
  output logic [uhist_pkg::OUT_COUNT_W-1:0] count
);
  import uhist_pkg::*;

  localparam int BIN_W = $clog2(BINS_MAX);
  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

  logic [SAMPLE_W-1:0]    min_value;
  logic [SCALE_W-1:0]     bin_scale;
  logic [BIN_COUNT_W-1:0] bin_count;
  logic                   in_take;
  logic                   out_take;
  logic [OCC_W-1:0]       occupied;
  logic                   clearing;
  uhist_op_t              op3;
  logic [BIN_W-1:0]       addr3;
  uhist_res_t             res;

  // Configuration registers. Software must write them only while the block is
  // idle, so the pipeline may read them without a snapshot (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      min_value <= MIN_VALUE_RST;
      bin_scale <= BIN_SCALE_RST;
      bin_count <= BIN_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_VALUE: min_value <= cfg_data;
        REG_BIN_SCALE: bin_scale <= cfg_data;
        REG_BIN_COUNT: bin_count <= cfg_data[BIN_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Every transfer accepted but not yet delivered holds a place in the result
  // queue, so the queue can never overflow and the pipeline never stops.
  // The input is held off while all places are taken or the bin memory is
  // still being cleared.
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = clearing || (occupied >= OCC_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else if (in_take && !out_take) begin
      occupied <= occupied + 1'b1;
    end else if (out_take && !in_take) begin
      occupied <= occupied - 1'b1;
    end
  end

  // Two register stages: the difference from the lower edge, then the scaled
  // product; the clamp to the bins in use forms the memory read address.
  uhist_bin_calc #(
    .BINS_MAX (BINS_MAX)
  ) u_calc (
    .clk       (clk),
    .rst       (rst),
    .take      (in_take),
    .command   (command),
    .sample    (sample),
    .bin_index (bin_index),
    .min_value (min_value),
    .bin_scale (bin_scale),
    .bin_count (bin_count),
    .op        (op3),
    .addr      (addr3)
  );

  // The memory stage reads the counter, updates it and writes it back in the
  // following cycle, forwarding the last write to the next operation.
  uhist_bin_mem #(
    .BINS_MAX    (BINS_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .op       (op3),
    .addr     (addr3),
    .clearing (clearing),
    .res      (res)
  );

  uhist_out_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bin_selected (bin_selected),
    .count        (count)
  );

  // Nothing is offered while no transfer is outstanding.
  `UHIST_ASSERT_IMPL(a_empty_no_out, clk, rst, occupied == '0, !out_valid)
  // The clearing sweep owns the memory port; no operation may reach it.
  `UHIST_ASSERT_IMPL(a_clear_no_op, clk, rst, clearing, !op3.valid)
  // A delivered result with no new input frees exactly one place.
  `UHIST_ASSERT_NEXT(a_drain, clk, rst, out_take && !in_take, occupied == $past(occupied) - 1'b1)

endmodule
`default_nettype wire

### tb/uniform_bin_histogram_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Uniform bin histogram testbench
// Streams add, read, read-and-clear and unused commands through the histogram
// under several register settings, with random gaps and output stalls, and
// compares every result with a bin-accurate prediction of the counters.
// ----------------------------------------------------------------------------
module uniform_bin_histogram_test;
  import uhist_pkg::*;

  // Command code the block has no use for: it must change nothing and report
  // the given index with a zero count.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int BINS = BINS_MAX_DEF;
  // Quiet cycles tolerated: the clearing pass after reset plus the longest
  // gap and stall, taken several times over.
  localparam int WATCHDOG_LIMIT = 3000;

  // Scoreboard: keeps its own copy of the registers and of every bin counter,
  // works out the result of each accepted command and checks the results in
  // order of arrival.
  class hist_scoreboard;
    typedef struct {
      logic [IDX_W-1:0]       sel;
      logic [OUT_COUNT_W-1:0] cnt;
    } bin_report_t;

    logic [SAMPLE_W-1:0]    min_edge;
    logic [SCALE_W-1:0]     scale;
    logic [BIN_COUNT_W-1:0] nbins;
    logic [OUT_COUNT_W-1:0] tally [BINS];
    bin_report_t            due_reports [$];
    int                     errors;

    function new();
      min_edge = MIN_VALUE_RST;
      scale    = BIN_SCALE_RST;
      nbins    = BIN_COUNT_RST;
      foreach (tally[i]) tally[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_VALUE: min_edge = data;
        REG_BIN_SCALE: scale = data;
        REG_BIN_COUNT: nbins = data[BIN_COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned bins_in_use();
      if (nbins == 0) return 1;
      if (nbins > BINS) return BINS;
      return nbins;
    endfunction

    function logic [IDX_W-1:0] bin_for_sample(logic [SAMPLE_W-1:0] smp);
      logic signed [SAMPLE_W:0] diff;
      logic [63:0]              prod;
      logic [31:0]              last;
      diff = $signed({smp[SAMPLE_W-1], smp}) - $signed({min_edge[SAMPLE_W-1], min_edge});
      last = bins_in_use() - 1;
      if (diff <= 0) return '0;
      // A positive difference fits in 32 bits, so the Q32.32 product is exact.
      prod = {32'd0, diff[31:0]} * {32'd0, scale};
      if (prod[63:32] > last) return last[IDX_W-1:0];
      return prod[32+IDX_W-1:32];
    endfunction

    function void note_transfer(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp,
                                logic [IDX_W-1:0] idx);
      bin_report_t r;
      r.sel = idx;
      r.cnt = '0;
      case (cmd)
        CMD_ADD: begin
          r.sel = bin_for_sample(smp);
          if (tally[r.sel] != '1) tally[r.sel] = tally[r.sel] + 1;
          r.cnt = tally[r.sel];
        end
        CMD_READ: r.cnt = tally[idx];
        CMD_READ_CLEAR: begin
          r.cnt = tally[idx];
          tally[idx] = '0;
        end
        default: ;
      endcase
      due_reports.push_back(r);
    endfunction

    function void check_result(logic [IDX_W-1:0] sel, logic [OUT_COUNT_W-1:0] cnt);
      bin_report_t r;
      if (due_reports.size() == 0) begin
        $display("%0t: result with none due: bin_selected %0d count %0d", $time, sel, cnt);
        errors++;
        return;
      end
      r = due_reports.pop_front();
      if (sel !== r.sel) begin
        $display("%0t: bin_selected expected %0d actual %0d", $time, r.sel, sel);
        errors++;
      end
      if (cnt !== r.cnt) begin
        $display("%0t: count expected %0d actual %0d (bin %0d)", $time, r.cnt, cnt, r.sel);
        errors++;
      end
    endfunction

    function int pending();
      return due_reports.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [CMD_W-1:0]       command;
  logic [SAMPLE_W-1:0]    sample;
  logic [IDX_W-1:0]       bin_index;
  logic                   out_valid;
  logic                   out_stall;
  logic [IDX_W-1:0]       bin_selected;
  logic [OUT_COUNT_W-1:0] count;

  hist_scoreboard sb;

  // Idling intensity of the current phase, shared by the sender and the
  // result stall: 0 none, 1 light, 2 heavy.
  int unsigned idle_mode;
  // Window of the current phase from which most samples are drawn.
  logic [SAMPLE_W-1:0] ph_min;
  int unsigned         ph_span;

  uniform_bin_histogram i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .sample       (sample),
    .bin_index    (bin_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bin_selected (bin_selected),
    .count        (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (idle_mode)
      1: begin
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 16);
      end
      2: begin
        if (r < 35) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(5, 30);
      end
      default: return 0;
    endcase
  endfunction

  // The result side stalls in bursts. Exactly one assignment to out_stall is
  // made per falling edge, so no stall level can be lost within a time step.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Result monitor and watchdog. Both sample at the rising edge, when every
  // input set up at the previous falling edge has settled. The watchdog counts
  // cycles in which no transfer happens on either side.
  initial begin
    int unsigned quiet;
    bit          moved;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        moved = in_valid && (in_stall === 1'b0);
        if (out_valid === 1'b1 && !out_stall) begin
          sb.check_result(bin_selected, count);
          moved = 1'b1;
        end
        quiet = moved ? 0 : quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // One register write. The block is idle whenever this is called, so the
  // scoreboard copy can be updated at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(logic [SAMPLE_W-1:0] lo, logic [SCALE_W-1:0] scl,
                           logic [BIN_COUNT_W-1:0] nb, int unsigned span);
    write_reg(REG_MIN_VALUE, lo);
    write_reg(REG_BIN_SCALE, scl);
    write_reg(REG_BIN_COUNT, {{(CFG_DATA_W-BIN_COUNT_W){1'b0}}, nb});
    ph_min  = lo;
    ph_span = span;
  endtask

  // Offers one command and holds it until the block takes it. Valid stays high
  // straight into the next command when no gap is drawn.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp,
                           logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    command   <= cmd;
    sample    <= smp;
    bin_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_transfer(cmd, smp, idx);
  endtask

  // Lets the pipeline run dry: the input goes idle, every due result must have
  // arrived, and a further idle wait passes before the next register write.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A setting such as software would program: a small number of units split
  // into one bin up to the full set of bins, around zero.
  task automatic random_setup();
    int unsigned nb;
    int unsigned w;
    logic [SAMPLE_W-1:0] lo;
    case ($urandom_range(0, 3))
      0: nb = 1;
      1: nb = 2;
      2: nb = BINS;
      default: nb = $urandom_range(3, BINS - 1);
    endcase
    w  = $urandom_range(1, 64);
    lo = $urandom_range(0, 200 << 16) - (100 << 16);
    configure(lo, (nb << 16) / w, nb[BIN_COUNT_W-1:0], w << 16);
  endtask

  // Random traffic: mostly adds of samples around the programmed range, the
  // rest reads, read-and-clears and the odd unused code. Small bin counts make
  // the same bin come back in neighbouring items, which tests forwarding.
  task automatic run_phase(int unsigned items);
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] smp;
    logic [IDX_W-1:0]    idx;
    int unsigned         r;
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < 78) cmd = CMD_ADD;
      else if (r < 88) cmd = CMD_READ;
      else if (r < 97) cmd = CMD_READ_CLEAR;
      else cmd = CMD_NONE;
      if ($urandom_range(0, 99) < 80)
        smp = ph_min + $urandom_range(0, ph_span + ph_span / 4) - ph_span / 8;
      else
        smp = $urandom;
      if ($urandom_range(0, 3) != 0) idx = $urandom_range(0, sb.bins_in_use() - 1);
      else idx = $urandom_range(0, BINS - 1);
      send_item(cmd, smp, idx);
    end
  endtask

  initial begin
    sb        = new();
    idle_mode = 1;
    ph_min    = '0;
    ph_span   = 1 << 16;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_MIN_VALUE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    command   = CMD_ADD;
    sample    = '0;
    bin_index = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part. One unit per bin, lower edge at zero.
    configure(32'h0000_0000, 32'h0001_0000, 9'd256, 64 << 16);
    send_item(CMD_ADD, 32'h0000_0000, 8'h00);  // exactly on the lower edge
    send_item(CMD_ADD, 32'hFFFF_FFFF, 8'hFF);  // just below it
    send_item(CMD_ADD, 32'h8000_0000, 8'h00);  // most negative sample
    send_item(CMD_ADD, 32'h7FFF_FFFF, 8'h00);  // far past the top: last bin
    send_item(CMD_ADD, 32'h0000_FFFF, 8'h00);  // just short of the second bin
    send_item(CMD_ADD, 32'h0001_0000, 8'h00);
    send_item(CMD_ADD, 32'h0005_8000, 8'h00);
    send_item(CMD_ADD, 32'h0005_0000, 8'h00);  // same bin straight after
    send_item(CMD_READ, 32'h0000_0000, 8'd5);
    send_item(CMD_READ_CLEAR, 32'h0000_0000, 8'd255);
    send_item(CMD_READ, 32'h0000_0000, 8'd255);
    send_item(CMD_READ_CLEAR, 32'h0000_0000, 8'd0);
    send_item(CMD_ADD, 32'h0000_0000, 8'h00);  // counts again from zero
    send_item(CMD_NONE, 32'h1234_5678, 8'hAA);
    send_item(CMD_READ, 32'hFFFF_FFFF, 8'h00);
    drain();

    // A bin count of zero behaves as a single bin; bins beyond the count in
    // use still hold their counters and can be read.
    configure(32'h8000_0000, 32'hFFFF_FFFF, 9'd0, 1 << 16);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 8'h00);
    send_item(CMD_READ, 32'h0000_0000, 8'd200);
    drain();

    // Zero scale sends everything to the first bin.
    configure(32'h8000_0000, 32'h0000_0000, 9'd511, 1 << 16);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 8'h00);
    drain();

    // A bin count above the maximum behaves as the full set of bins.
    configure(32'h8000_0000, 32'hFFFF_FFFF, 9'd511, 1 << 16);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 8'h00);
    send_item(CMD_ADD, 32'h8000_0001, 8'h00);
    send_item(CMD_ADD, 32'h8000_0002, 8'h00);
    send_item(CMD_READ_CLEAR, 32'h0000_0000, 8'd255);
    drain();

    // Random part. Phases cycle through no idling, light and heavy idling;
    // the last two use a fully random setting and one that spreads the whole
    // sample range over all bins.
    for (int p = 0; p < 6; p++) begin
      idle_mode = p % 3;
      if (p < 4)
        random_setup();
      else if (p == 4)
        configure($urandom, $urandom, $urandom_range(0, 511), $urandom_range(1 << 16, 1 << 30));
      else
        configure(32'h8000_0000, 32'h0000_0100, 9'd256, 32'h4000_0000);
      run_phase(90);
      drain();
    end

    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
